// File: hdl/nnps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnps_pkg
// Shared types, constants and helper functions of the nearest-neighbor
// pixel scaler.
// ----------------------------------------------------------------------------
package nnps_pkg;

    localparam int MAX_REPEAT = 64;
    localparam int REP_W      = 7;
    localparam int SRC_W      = 14;
    localparam int DST_W      = 16;
    localparam int PIX_W      = 24;
    localparam int SRC_MAX    = 8192;
    localparam int DIV_W      = 18;
    localparam int DIV_STEPS  = 18;
    localparam int DCNT_W     = 5;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int USER_W     = 3;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_SRC_WIDTH  = 3'd0;
    localparam reg_idx_t REG_SRC_HEIGHT = 3'd1;
    localparam reg_idx_t REG_DST_WIDTH  = 3'd2;
    localparam reg_idx_t REG_DST_HEIGHT = 3'd3;
    localparam reg_idx_t REG_ENLARGE    = 3'd4;

    typedef struct packed {
        logic [SRC_W-1:0] src_width;
        logic [SRC_W-1:0] src_height;
        logic [DST_W-1:0] dst_width;
        logic [DST_W-1:0] dst_height;
        logic             enlarge;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [REP_W-1:0] count;
        logic             row_end;
        logic             repeat_row;
        logic             frame_end;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DST_W-1:0] a;
        logic [DST_W-1:0] b;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [REP_W-1:0] q;
    } div_rsp_t;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_PREP,
        FE_ROW_WAIT,
        FE_COL,
        FE_COL_WAIT,
        FE_UPD
    } fe_state_t;

    function automatic logic [SRC_W-1:0] eff_src(input logic [SRC_W-1:0] v);
        logic [SRC_W-1:0] r;
        if (v == '0) begin
            r = SRC_W'(1);
        end else if (v > SRC_W'(SRC_MAX)) begin
            r = SRC_W'(SRC_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [DST_W-1:0] eff_dst(input logic [DST_W-1:0] v);
        return (v == '0) ? DST_W'(1) : v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/nnps_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnps_div
// Iterative half-up rounding divider, one quotient bit per cycle, with the
// quotient saturated at the largest group size.
// ----------------------------------------------------------------------------
module nnps_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire nnps_pkg::div_req_t req,
    output nnps_pkg::div_rsp_t      rsp
);
    import nnps_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-2:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-2:0]  den_reg, den_next;
    logic [DIV_W-1:0]  shifted;
    logic [DIV_W-1:0]  diff;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start) begin
            if (req.b == '0) begin
                quo_next  = {2'b00, req.a};
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                quo_next  = {1'b0, req.a, 1'b0} + {2'b00, req.b};
                rem_next  = '0;
                den_next  = {req.b, 1'b0};
                cnt_next  = DCNT_W'(DIV_STEPS - 1);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIV_W-2:0] : shifted[DIV_W-2:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = (quo_reg > DIV_W'(MAX_REPEAT)) ? REP_W'(MAX_REPEAT)
                                                     : quo_reg[REP_W-1:0];

endmodule
`default_nettype wire

// File: hdl/nnps_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnps_front
// Accepts source pixels, tracks the row and column position of the frame,
// sizes the row and column groups and queues a request for each pixel with copies.
// ----------------------------------------------------------------------------
module nnps_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire nnps_pkg::cfg_t                cfg,
    input  wire logic                          cfg_clr,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [nnps_pkg::PIX_W-1:0]    s_tdata,
    output nnps_pkg::div_req_t                 div_req,
    input  wire nnps_pkg::div_rsp_t            div_rsp,
    input  wire logic                          q_full,
    output logic                               q_push,
    output nnps_pkg::entry_t                   q_entry
);
    import nnps_pkg::*;

    fe_state_t        state_reg, state_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic [SRC_W-1:0] srl_reg, srl_next;
    logic [DST_W-1:0] drl_reg, drl_next;
    logic [REP_W-1:0] rgs_reg, rgs_next;
    logic [REP_W-1:0] rpi_reg, rpi_next;
    logic [SRC_W-1:0] scl_reg, scl_next;
    logic [DST_W-1:0] dcl_reg, dcl_next;
    logic [REP_W-1:0] cgs_reg, cgs_next;
    logic [REP_W-1:0] ci_reg, ci_next;

    logic             row_div;
    logic             col_div;
    logic [SRC_W-1:0] grp_src;
    logic [REP_W-1:0] grp_min1;
    logic [REP_W-1:0] grp_size;

    logic [SRC_W-1:0] u_srl;
    logic [DST_W-1:0] u_drl;
    logic [REP_W-1:0] u_rpi;
    logic [SRC_W-1:0] u_scl;
    logic [DST_W-1:0] u_dcl;
    logic [REP_W-1:0] u_ci;
    logic [REP_W-1:0] u_n;
    logic             u_row_end;
    logic             u_rep;
    logic             u_fe;
    logic [REP_W-1:0] rpi_inc;
    logic [REP_W-1:0] ci_inc;
    logic             grp_done;
    logic             out_row;
    logic             emit;

    assign row_div = (scl_reg == '0) && (rpi_reg == '0);
    assign col_div = cfg.enlarge || (ci_reg == '0);

    // Group size from the divider, with the shrink-mode limits applied.
    assign grp_src  = (state_reg == FE_ROW_WAIT) ? srl_reg : scl_reg;
    assign grp_min1 = (div_rsp.q == '0) ? REP_W'(1) : div_rsp.q;
    always_comb begin
        if (cfg.enlarge) begin
            grp_size = div_rsp.q;
        end else if ({{(SRC_W-REP_W){1'b0}}, grp_min1} > grp_src) begin
            grp_size = grp_src[REP_W-1:0];
        end else begin
            grp_size = grp_min1;
        end
    end

    always_comb begin
        rpi_inc   = rpi_reg + REP_W'(1);
        ci_inc    = ci_reg + REP_W'(1);
        grp_done  = ci_inc >= cgs_reg;
        out_row   = (({1'b0, rpi_reg} + 8'd1) == {1'b0, rgs_reg}) && (drl_reg != '0);
        emit      = 1'b0;
        u_srl     = srl_reg;
        u_drl     = drl_reg;
        u_rpi     = rpi_reg;
        u_scl     = scl_reg;
        u_dcl     = dcl_reg;
        u_ci      = ci_reg;
        u_n       = '0;
        u_row_end = 1'b0;
        u_rep     = 1'b0;
        u_fe      = 1'b0;
        if (cfg.enlarge) begin
            u_n   = (rgs_reg == '0) ? '0 : cgs_reg;
            u_dcl = dcl_reg - {{(DST_W-REP_W){1'b0}}, cgs_reg};
            u_scl = scl_reg - SRC_W'(1);
            if (u_scl == '0) begin
                u_row_end = 1'b1;
                u_rep     = rpi_inc < rgs_reg;
                if (u_rep) begin
                    u_rpi = rpi_inc;
                end else begin
                    u_drl = (drl_reg > {{(DST_W-REP_W){1'b0}}, rgs_reg})
                          ? drl_reg - {{(DST_W-REP_W){1'b0}}, rgs_reg} : '0;
                    u_srl = srl_reg - SRC_W'(1);
                    u_rpi = '0;
                    u_fe  = (u_srl == '0);
                end
            end
        end else begin
            if (grp_done) begin
                emit  = out_row && (dcl_reg != '0);
                u_scl = scl_reg - {{(SRC_W-REP_W){1'b0}}, cgs_reg};
                u_dcl = (dcl_reg != '0) ? dcl_reg - DST_W'(1) : '0;
                u_ci  = '0;
                if (emit && (u_dcl == '0)) begin
                    u_row_end = 1'b1;
                    u_fe      = (drl_reg == DST_W'(1));
                end
            end else begin
                u_ci = ci_inc;
            end
            if (u_scl == '0) begin
                if (rpi_inc >= rgs_reg) begin
                    u_srl = srl_reg - {{(SRC_W-REP_W){1'b0}}, rgs_reg};
                    u_drl = (drl_reg != '0) ? drl_reg - DST_W'(1) : '0;
                    u_rpi = '0;
                end else begin
                    u_rpi = rpi_inc;
                end
            end
            u_n = emit ? REP_W'(1) : '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE: begin
                if (s_tvalid) begin
                    state_next = FE_PREP;
                end
            end
            FE_PREP: begin
                state_next = row_div ? FE_ROW_WAIT : FE_COL;
            end
            FE_ROW_WAIT: begin
                if (div_rsp.done) begin
                    state_next = FE_COL;
                end
            end
            FE_COL: begin
                state_next = col_div ? FE_COL_WAIT : FE_UPD;
            end
            FE_COL_WAIT: begin
                if (div_rsp.done) begin
                    state_next = FE_UPD;
                end
            end
            FE_UPD: begin
                if (!q_full) begin
                    state_next = FE_IDLE;
                end
            end
            default: begin
                state_next = FE_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        div_req.start = 1'b0;
        q_push        = 1'b0;
        if (state_reg == FE_PREP) begin
            div_req.a = cfg.enlarge ? drl_reg : {{(DST_W-SRC_W){1'b0}}, srl_reg};
            div_req.b = cfg.enlarge ? {{(DST_W-SRC_W){1'b0}}, srl_reg} : drl_reg;
        end else begin
            div_req.a = cfg.enlarge ? dcl_reg : {{(DST_W-SRC_W){1'b0}}, scl_reg};
            div_req.b = cfg.enlarge ? {{(DST_W-SRC_W){1'b0}}, scl_reg} : dcl_reg;
        end
        case (state_reg)
            FE_IDLE: begin
                s_tready = 1'b1;
            end
            FE_PREP: begin
                div_req.start = row_div;
            end
            FE_COL: begin
                div_req.start = col_div;
            end
            FE_UPD: begin
                q_push = !q_full && (u_n != '0);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign q_entry.pixel      = pix_reg;
    assign q_entry.count      = u_n;
    assign q_entry.row_end    = u_row_end;
    assign q_entry.repeat_row = u_rep;
    assign q_entry.frame_end  = u_fe;

    always_comb begin
        pix_next = pix_reg;
        srl_next = srl_reg;
        drl_next = drl_reg;
        rgs_next = rgs_reg;
        rpi_next = rpi_reg;
        scl_next = scl_reg;
        dcl_next = dcl_reg;
        cgs_next = cgs_reg;
        ci_next  = ci_reg;
        case (state_reg)
            FE_IDLE: begin
                if (s_tvalid) begin
                    pix_next = s_tdata;
                    if (srl_reg == '0) begin
                        srl_next = eff_src(cfg.src_height);
                        drl_next = eff_dst(cfg.dst_height);
                        rpi_next = '0;
                        scl_next = '0;
                    end
                end
            end
            FE_PREP: begin
                if (scl_reg == '0) begin
                    scl_next = eff_src(cfg.src_width);
                    dcl_next = eff_dst(cfg.dst_width);
                    ci_next  = '0;
                end
            end
            FE_ROW_WAIT: begin
                if (div_rsp.done) begin
                    rgs_next = grp_size;
                end
            end
            FE_COL_WAIT: begin
                if (div_rsp.done) begin
                    cgs_next = grp_size;
                end
            end
            FE_UPD: begin
                if (!q_full) begin
                    srl_next = u_srl;
                    drl_next = u_drl;
                    rpi_next = u_rpi;
                    scl_next = u_scl;
                    dcl_next = u_dcl;
                    ci_next  = u_ci;
                end
            end
            default: begin
                pix_next = pix_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clr) begin
            state_reg <= FE_IDLE;
            srl_reg   <= '0;
            drl_reg   <= '0;
            rgs_reg   <= '0;
            rpi_reg   <= '0;
            scl_reg   <= '0;
            dcl_reg   <= '0;
            cgs_reg   <= '0;
            ci_reg    <= '0;
        end else begin
            state_reg <= state_next;
            srl_reg   <= srl_next;
            drl_reg   <= drl_next;
            rgs_reg   <= rgs_next;
            rpi_reg   <= rpi_next;
            scl_reg   <= scl_next;
            dcl_reg   <= dcl_next;
            cgs_reg   <= cgs_next;
            ci_reg    <= ci_next;
        end
        pix_reg <= pix_next;
    end

endmodule
`default_nettype wire

// File: hdl/nnps_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnps_queue
// Two-entry request queue between the front and the output stage.
// ----------------------------------------------------------------------------
module nnps_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire nnps_pkg::entry_t wr_entry,
    output logic                  full,
    input  wire logic             pop,
    output nnps_pkg::entry_t      rd_entry,
    output logic                  empty
);
    import nnps_pkg::*;

    entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule
`default_nettype wire

// File: hdl/nnps_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnps_back
// Output stage: replays each queued pixel as many times as its request says
// and places the row and frame flags on the last copy.
// ----------------------------------------------------------------------------
module nnps_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_empty,
    input  wire nnps_pkg::entry_t               q_head,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [nnps_pkg::PIX_W-1:0]          m_tdata,
    output logic                                m_tlast,
    output logic [nnps_pkg::USER_W-1:0]         m_tuser
);
    import nnps_pkg::*;

    logic             active_reg, active_next;
    logic [REP_W-1:0] cnt_reg, cnt_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic             re_reg, re_next;
    logic             rep_reg, rep_next;
    logic             fe_reg, fe_next;
    logic             last;
    logic             load;

    assign last  = (cnt_reg == REP_W'(1));
    assign load  = !q_empty && (!active_reg || (m_tready && last));
    assign q_pop = load;

    always_comb begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        pix_next    = pix_reg;
        re_next     = re_reg;
        rep_next    = rep_reg;
        fe_next     = fe_reg;
        if (load) begin
            active_next = 1'b1;
            cnt_next    = q_head.count;
            pix_next    = q_head.pixel;
            re_next     = q_head.row_end;
            rep_next    = q_head.repeat_row;
            fe_next     = q_head.frame_end;
        end else if (active_reg && m_tready) begin
            if (last) begin
                active_next = 1'b0;
            end
            cnt_next = cnt_reg - REP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
        pix_reg <= pix_next;
        re_reg  <= re_next;
        rep_reg <= rep_next;
        fe_reg  <= fe_next;
    end

    assign m_tvalid = active_reg;
    assign m_tdata  = pix_reg;
    assign m_tlast  = last;
    assign m_tuser  = {fe_reg && last, rep_reg && last, re_reg && last};

endmodule
`default_nettype wire

// File: hdl/nearest_neighbor_pixel_scaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_pixel_scaler
// Nearest-neighbor image scaler for 24-bit pixels in raster order, with
// pixel and row replication or decimation set by the configuration registers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_       in         source pixel (tdata[23:0])
//  m_       out        pixel (tdata), run end (tlast), row/repeat/frame flags (tuser)
//  APB      in/out     src_width, src_height, dst_width, dst_height, enlarge
//
// For each pixel the front asks the 18-step shared divider for rounded group
// divisions: one for the column group in enlarge mode or at a column group
// start, one more at a row group start.
// The output side gives one copy per cycle while m_tready is high.
// Reset is synchronous; a write to a listed register clears the scan position.
// The two-entry queue lets the front keep working while the output stalls.
module nearest_neighbor_pixel_scaler (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [nnps_pkg::PIX_W-1:0]      s_tdata,   // [23:0] pixel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [nnps_pkg::PIX_W-1:0]           m_tdata,   // [23:0] pixel_out
    output logic                                 m_tlast,
    output logic [nnps_pkg::USER_W-1:0]          m_tuser,   // [0] row_end, [1] repeat_row,
                                                            // [2] frame_end
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [nnps_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [nnps_pkg::DATA_W-1:0]     pwdata,
    output logic [nnps_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import nnps_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     wr_en;
    logic     cfg_clr;
    reg_idx_t idx;
    div_req_t div_req;
    div_rsp_t div_rsp;
    entry_t   push_entry;
    entry_t   head_entry;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        cfg_clr  = 1'b0;
        if (wr_en) begin
            cfg_clr = 1'b1;
            case (idx)
                REG_SRC_WIDTH:  cfg_next.src_width  = pwdata[SRC_W-1:0];
                REG_SRC_HEIGHT: cfg_next.src_height = pwdata[SRC_W-1:0];
                REG_DST_WIDTH:  cfg_next.dst_width  = pwdata[DST_W-1:0];
                REG_DST_HEIGHT: cfg_next.dst_height = pwdata[DST_W-1:0];
                REG_ENLARGE:    cfg_next.enlarge    = pwdata[0];
                default:        cfg_clr             = 1'b0;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SRC_WIDTH:  prdata = {{(DATA_W-SRC_W){1'b0}}, cfg_reg.src_width};
            REG_SRC_HEIGHT: prdata = {{(DATA_W-SRC_W){1'b0}}, cfg_reg.src_height};
            REG_DST_WIDTH:  prdata = {{(DATA_W-DST_W){1'b0}}, cfg_reg.dst_width};
            REG_DST_HEIGHT: prdata = {{(DATA_W-DST_W){1'b0}}, cfg_reg.dst_height};
            REG_ENLARGE:    prdata = {{(DATA_W-1){1'b0}}, cfg_reg.enlarge};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width  <= SRC_W'(1);
            cfg_reg.src_height <= SRC_W'(1);
            cfg_reg.dst_width  <= DST_W'(1);
            cfg_reg.dst_height <= DST_W'(1);
            cfg_reg.enlarge    <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    nnps_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cfg_clr  (cfg_clr),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    nnps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    nnps_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (push_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (head_entry),
        .empty    (q_empty)
    );

    nnps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// File: hdl/nnps_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnps_checker
// Port-level checks of the scaler's result channel.
// ----------------------------------------------------------------------------
module nnps_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [2:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_repeat_on_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast)
        else $error("repeat_row without row_end on the last copy");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[0] && m_tlast && !m_tuser[1])
        else $error("frame_end without row_end or with repeat_row");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind nearest_neighbor_pixel_scaler nnps_checker u_nnps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// File: test/nearest_neighbor_pixel_scaler_tb.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_pixel_scaler_tb
// Self-checking bench for the nearest-neighbor pixel scaler. Source pixels
// are fed as whole frames, with some broken and partial frames, under many
// register settings. Each accepted pixel is run through a scaling predictor
// that keeps its own scan position. Every output pixel is compared with the
// oldest predicted one. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module nearest_neighbor_pixel_scaler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnps_pkg::*;

    localparam reg_idx_t REG_UNUSED    = 3'd5;
    localparam int       PIXEL_TARGET  = 370;
    localparam int       CALM_PIXELS   = 40;
    localparam int       SETTLE_CYCLES = 200;
    localparam int       HOLD_CYCLES   = 400;
    localparam int       CYCLE_LIMIT   = 2000000;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             row_end;
        logic             repeat_row;
        logic             frame_end;
    } scaled_pixel_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [PIX_W-1:0]    s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [PIX_W-1:0]    m_tdata;
    logic                m_tlast;
    logic [USER_W-1:0]   m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    nearest_neighbor_pixel_scaler u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Register copies.
    logic [SRC_W-1:0] cfg_src_w  = SRC_W'(1);
    logic [SRC_W-1:0] cfg_src_h  = SRC_W'(1);
    logic [DST_W-1:0] cfg_dst_w  = DST_W'(1);
    logic [DST_W-1:0] cfg_dst_h  = DST_W'(1);
    logic             cfg_enlarge = 1'b1;

    // Scan position.
    logic [SRC_W-1:0] rows_src_left = '0;
    logic [DST_W-1:0] rows_dst_left = '0;
    logic [REP_W-1:0] row_span      = '0;
    logic [REP_W-1:0] row_pass      = '0;
    logic [SRC_W-1:0] cols_src_left = '0;
    logic [DST_W-1:0] cols_dst_left = '0;
    logic [REP_W-1:0] col_span      = '0;
    logic [REP_W-1:0] col_pos       = '0;

    logic [PIX_W-1:0] src_pixels[$];
    scaled_pixel_t    due_pixels[$];
    scaled_pixel_t    got;
    scaled_pixel_t    want;

    int  pixels_queued  = 0;
    int  mismatch_count = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  cycle_count    = 0;
    logic calm_tail     = 1'b0;

    function automatic int unsigned src_extent(input logic [SRC_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        return (v > SRC_MAX) ? SRC_MAX : v;
    endfunction

    function automatic int unsigned dst_extent(input logic [DST_W-1:0] v);
        return (v == '0) ? 1 : v;
    endfunction

    function automatic int unsigned rounded_quotient(input int unsigned a,
                                                     input int unsigned b);
        if (b == 0) begin
            return a;
        end
        return (2 * a + b) / (2 * b);
    endfunction

    function automatic int unsigned clamp_repeat(input int unsigned g);
        return (g > MAX_REPEAT) ? MAX_REPEAT : g;
    endfunction

    function automatic int unsigned shrink_span(input int unsigned src_left,
                                                input int unsigned dst_left);
        int unsigned g;
        g = rounded_quotient(src_left, dst_left);
        if (g < 1) begin
            g = 1;
        end
        if (g > src_left) begin
            g = src_left;
        end
        return clamp_repeat(g);
    endfunction

    function automatic void clear_scan();
        rows_src_left = '0;
        rows_dst_left = '0;
        row_span      = '0;
        row_pass      = '0;
        cols_src_left = '0;
        cols_dst_left = '0;
        col_span      = '0;
        col_pos       = '0;
    endfunction

    task automatic scale_pixel(input logic [PIX_W-1:0] px);
        int unsigned   copies;
        int unsigned   k;
        logic          row_done;
        logic          again;
        logic          frame_done;
        logic          out_row;
        logic          emit;
        scaled_pixel_t copy;
        copies     = 0;
        row_done   = 1'b0;
        again      = 1'b0;
        frame_done = 1'b0;
        emit       = 1'b0;
        if (rows_src_left == '0) begin
            rows_src_left = SRC_W'(src_extent(cfg_src_h));
            rows_dst_left = DST_W'(dst_extent(cfg_dst_h));
            row_pass      = '0;
            cols_src_left = '0;
        end
        if (cfg_enlarge) begin
            if (cols_src_left == '0) begin
                if (row_pass == '0) begin
                    row_span = REP_W'(clamp_repeat(
                        rounded_quotient(rows_dst_left, rows_src_left)));
                end
                cols_src_left = SRC_W'(src_extent(cfg_src_w));
                cols_dst_left = DST_W'(dst_extent(cfg_dst_w));
            end
            col_span = REP_W'(clamp_repeat(rounded_quotient(cols_dst_left, cols_src_left)));
            copies = (row_span == '0) ? 0 : col_span;
            cols_dst_left = cols_dst_left - col_span;
            cols_src_left = cols_src_left - 1'b1;
            if (cols_src_left == '0) begin
                row_done = 1'b1;
                row_pass = row_pass + 1'b1;
                again = (row_pass < row_span);
                if (!again) begin
                    rows_dst_left = (rows_dst_left > row_span) ? rows_dst_left - row_span : '0;
                    rows_src_left = rows_src_left - 1'b1;
                    row_pass = '0;
                    frame_done = (rows_src_left == '0);
                end
            end
        end else begin
            if (cols_src_left == '0) begin
                if (row_pass == '0) begin
                    row_span = REP_W'(shrink_span(rows_src_left, rows_dst_left));
                end
                cols_src_left = SRC_W'(src_extent(cfg_src_w));
                cols_dst_left = DST_W'(dst_extent(cfg_dst_w));
                col_pos = '0;
            end
            if (col_pos == '0) begin
                col_span = REP_W'(shrink_span(cols_src_left, cols_dst_left));
            end
            out_row = (row_pass + 1 == row_span) && (rows_dst_left > 0);
            col_pos = col_pos + 1'b1;
            if (col_pos >= col_span) begin
                emit = out_row && (cols_dst_left > 0);
                cols_src_left = cols_src_left - col_span;
                if (cols_dst_left > 0) begin
                    cols_dst_left = cols_dst_left - 1'b1;
                end
                col_pos = '0;
                if (emit && cols_dst_left == '0) begin
                    row_done = 1'b1;
                    frame_done = (rows_dst_left == 1);
                end
            end
            if (cols_src_left == '0) begin
                row_pass = row_pass + 1'b1;
                if (row_pass >= row_span) begin
                    rows_src_left = rows_src_left - row_span;
                    if (rows_dst_left > 0) begin
                        rows_dst_left = rows_dst_left - 1'b1;
                    end
                    row_pass = '0;
                end
            end
            copies = emit ? 1 : 0;
        end
        for (k = 0; k < copies; k++) begin
            copy.pixel      = px;
            copy.last       = (k + 1 == copies);
            copy.row_end    = copy.last && row_done;
            copy.repeat_row = copy.last && again;
            copy.frame_end  = copy.last && frame_done;
            due_pixels.push_back(copy);
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL nearest_neighbor_pixel_scaler");
            $finish;
        end
    end

    // Source side: one request per pixel, with random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                scale_pixel(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (!calm_tail && src_pixels.size() > 0
                             && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 12);
                    s_tvalid <= 1'b0;
                end else if (src_pixels.size() > 0) begin
                    s_tdata  <= src_pixels.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each accepted request, then pick the next ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.pixel      = m_tdata;
                got.last       = m_tlast;
                got.row_end    = m_tuser[0];
                got.repeat_row = m_tuser[1];
                got.frame_end  = m_tuser[2];
                if (due_pixels.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) begin
                        $display("unexpected: pixel %h last %b re %b rep %b fe %b",
                                 got.pixel, got.last, got.row_end, got.repeat_row,
                                 got.frame_end);
                    end
                end else begin
                    want = due_pixels.pop_front();
                    if (got != want) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected pixel %h last %b re %b rep %b fe %b",
                                     want.pixel, want.last, want.row_end, want.repeat_row,
                                     want.frame_end);
                            $display("          actual   pixel %h last %b re %b rep %b fe %b",
                                     got.pixel, got.last, got.row_end, got.repeat_row,
                                     got.frame_end);
                        end
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  cfg_src_w   = value[SRC_W-1:0];
            REG_SRC_HEIGHT: cfg_src_h   = value[SRC_W-1:0];
            REG_DST_WIDTH:  cfg_dst_w   = value[DST_W-1:0];
            REG_DST_HEIGHT: cfg_dst_h   = value[DST_W-1:0];
            REG_ENLARGE:    cfg_enlarge = value[0];
            default:        return;
        endcase
        clear_scan();
    endtask

    task automatic configure(input logic [DATA_W-1:0] src_w, input logic [DATA_W-1:0] src_h,
                             input logic [DATA_W-1:0] dst_w, input logic [DATA_W-1:0] dst_h,
                             input logic [DATA_W-1:0] enl);
        write_register(REG_SRC_WIDTH, src_w);
        write_register(REG_SRC_HEIGHT, src_h);
        write_register(REG_DST_WIDTH, dst_w);
        write_register(REG_DST_HEIGHT, dst_h);
        write_register(REG_ENLARGE, enl);
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] px);
        src_pixels.push_back(px);
        pixels_queued = pixels_queued + 1;
    endtask

    // A well-formed frame: in enlarge mode each source row is presented as
    // many times as its row group asks for.
    task automatic build_frame(ref logic [PIX_W-1:0] frame[$]);
        int unsigned      rows_left;
        int unsigned      dst_left;
        int unsigned      width;
        int unsigned      g;
        int unsigned      passes;
        logic [PIX_W-1:0] row[$];
        rows_left = src_extent(cfg_src_h);
        dst_left  = dst_extent(cfg_dst_h);
        width     = src_extent(cfg_src_w);
        frame.delete();
        while (rows_left > 0) begin
            row.delete();
            repeat (width) row.push_back(PIX_W'($urandom()));
            if (cfg_enlarge) begin
                g = clamp_repeat(rounded_quotient(dst_left, rows_left));
                passes = (g == 0) ? 1 : g;
                dst_left = (dst_left > g) ? dst_left - g : 0;
            end else begin
                passes = 1;
            end
            repeat (passes) frame = {frame, row};
            rows_left = rows_left - 1;
        end
    endtask

    task automatic queue_frame();
        logic [PIX_W-1:0] frame[$];
        build_frame(frame);
        foreach (frame[i]) push_pixel(frame[i]);
    endtask

    task automatic drain();
        while (src_pixels.size() > 0 || s_tvalid || due_pixels.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_setup();
        int unsigned sw;
        int unsigned sh;
        if ($urandom_range(0, 1) == 1) begin
            sw = $urandom_range(1, 6);
            sh = $urandom_range(1, 4);
            configure(sw, sh, $urandom_range(1, 4 * sw), $urandom_range(1, 4 * sh), 1);
        end else begin
            sw = $urandom_range(1, 10);
            sh = $urandom_range(1, 5);
            configure(sw, sh, $urandom_range(1, sw + 2), $urandom_range(1, sh + 1), 0);
        end
    endtask

    initial begin
        logic [PIX_W-1:0] frame[$];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one pixel per frame.
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        settle();

        // Column group saturates at the repeat limit.
        configure(1, 1, 200, 1, 1);
        push_pixel(24'hA5C35A);
        settle();

        // Row group saturates; every row asks to be repeated.
        configure(1, 1, 1, 100, 1);
        repeat (3) push_pixel(PIX_W'($urandom()));
        settle();

        // Enlarge with groups that round to zero.
        configure(3, 2, 2, 1, 1);
        queue_frame();
        settle();

        // Out-of-range and extreme register values.
        configure(32'hFFFF_FFFF, 0, 65535, 0, 1);
        repeat (2) push_pixel(PIX_W'($urandom()));
        settle();
        configure(0, 8193, 0, 65535, 1);
        repeat (3) push_pixel(PIX_W'($urandom()));
        settle();

        // Shrink, plain and with more destination than source pixels.
        configure(4, 2, 2, 1, 0);
        queue_frame();
        settle();
        configure(3, 1, 5, 1, 0);
        queue_frame();
        settle();

        // A write to an unlisted register must not disturb the scan position.
        configure(3, 2, 6, 4, 1);
        repeat (4) push_pixel(PIX_W'($urandom()));
        settle();
        write_register(REG_UNUSED, $urandom());
        repeat (8) push_pixel(PIX_W'($urandom()));
        settle();

        // Shrink where the destination runs out before the source.
        configure(65, 1, 1, 1, 0);
        queue_frame();
        settle();
        configure(1, 65, 1, 1, 0);
        queue_frame();
        settle();

        // Long output stall while the source keeps offering pixels.
        configure(4, 2, 12, 6, 1);
        queue_frame();
        hold_requests = hold_requests + 1;
        settle();

        // Source pauses mid-frame until the output has caught up.
        configure(5, 3, 10, 6, 1);
        build_frame(frame);
        for (int i = 0; i < frame.size() / 2; i++) push_pixel(frame[i]);
        drain();
        for (int i = frame.size() / 2; i < frame.size(); i++) push_pixel(frame[i]);
        settle();

        while (pixels_queued < PIXEL_TARGET - CALM_PIXELS) begin
            random_setup();
            repeat ($urandom_range(1, 2)) queue_frame();
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 5)) push_pixel(PIX_W'($urandom()));
            end
            settle();
        end

        calm_tail = 1'b1;
        random_setup();
        while (pixels_queued < PIXEL_TARGET) begin
            queue_frame();
        end
        settle();

        if (mismatch_count == 0 && due_pixels.size() == 0) begin
            $display("PASS nearest_neighbor_pixel_scaler");
        end else begin
            $display("FAIL nearest_neighbor_pixel_scaler");
        end
        $finish;
    end

endmodule
